[sv/msba_pkg.sv]
// ---------------------------------------------------------------------------
// msba_pkg
// Shared types and constants for the multi-sender bit assembler.
// ---------------------------------------------------------------------------
package msba_pkg;

   localparam int SENDER_W      = 22;
   localparam int BYTE_W        = 8;
   localparam int COUNT_W       = 3;
   localparam int SLOTS_DEFAULT = 8;

   // result status codes
   localparam logic STATUS_COMPLETE = 1'b0;
   localparam logic STATUS_DROPPED  = 1'b1;

   // last bit position of a byte
   localparam logic [COUNT_W-1:0] LAST_POS = COUNT_W'(BYTE_W - 1);

   typedef logic [SENDER_W-1:0] sender_type;
   typedef logic [BYTE_W-1:0]   byte_type;
   typedef logic [COUNT_W-1:0]  count_type;

   // one stored assembly
   typedef struct packed {
      sender_type sender;
      count_type  count;
      byte_type   data;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic update;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic needs_rsp;
      logic rsp_busy;
   } stat_type;

endpackage

[sv/msba_req_if.sv]
// ---------------------------------------------------------------------------
// msba_req_if
// Input channel: one received bit tagged with its sender.
// ---------------------------------------------------------------------------
interface msba_req_if import msba_pkg::*; ();

   logic       valid;
   logic       ready;
   sender_type sender_id;
   logic       bit_value;

   modport source (output valid, output sender_id, output bit_value, input ready);
   modport sink   (input valid, input sender_id, input bit_value, output ready);

endinterface

[sv/msba_rsp_if.sv]
// ---------------------------------------------------------------------------
// msba_rsp_if
// Result channel: completed byte or dropped-bit notice.
// ---------------------------------------------------------------------------
interface msba_rsp_if import msba_pkg::*; ();

   logic       valid;
   logic       ready;
   sender_type result_sender;
   byte_type   data_byte;
   logic       status;

   modport source (output valid, output result_sender, output data_byte,
                   output status, input ready);
   modport sink   (input valid, input result_sender, input data_byte,
                   input status, output ready);

endinterface

[sv/msba_ctrl.sv]
// ---------------------------------------------------------------------------
// msba_ctrl
// Sequencer: accept a transaction, run the table scan, apply the update.
// ---------------------------------------------------------------------------
module msba_ctrl import msba_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       upd_ok;

   assign req_ready = (state_ff == ST_IDLE);
   // update waits only when it produces a result and the output slot is full
   assign upd_ok    = !stat.needs_rsp || !stat.rsp_busy;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.update = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               state_in = ST_UPDATE;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         ST_UPDATE: begin
            if (upd_ok) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/msba_dpath.sv]
// ---------------------------------------------------------------------------
// msba_dpath
// Assembly table, scan pipeline, entry update and result register.
// ---------------------------------------------------------------------------
module msba_dpath import msba_pkg::*; #(
   parameter int SENDER_SLOTS = SLOTS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output stat_type   stat,
   input  sender_type req_sender_id,
   input  logic       req_bit_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output sender_type rsp_result_sender,
   output byte_type   rsp_data_byte,
   output logic       rsp_status
);

   localparam int IdxW = (SENDER_SLOTS > 1) ? $clog2(SENDER_SLOTS) : 1;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(SENDER_SLOTS - 1);

   // table storage: valid bits in flops, entry contents in memory
   logic [SENDER_SLOTS-1:0] valid_ff;
   entry_type               mem [SENDER_SLOTS];

   // captured transaction
   sender_type who_ff;
   logic       bit_ff;

   // scan pipeline
   logic [IdxW-1:0] idx_ff;
   logic            issue_ff;
   logic            chk_ff;
   entry_type       rd_ff;
   logic [IdxW-1:0] rd_idx_ff;

   // scan results
   logic            hit_ff;
   logic [IdxW-1:0] hit_idx_ff;
   count_type       hit_cnt_ff;
   byte_type        hit_data_ff;
   logic            free_ff;
   logic [IdxW-1:0] free_idx_ff;

   // result register
   logic       rsp_valid_ff;
   sender_type rsp_sender_ff;
   byte_type   rsp_data_ff;
   logic       rsp_status_ff;

   logic     is_match;
   logic     is_free;
   byte_type new_data;
   logic     completes;
   logic     rsp_fire;

   assign is_match  = chk_ff && valid_ff[rd_idx_ff] && (rd_ff.sender == who_ff);
   assign is_free   = chk_ff && !valid_ff[rd_idx_ff];
   assign new_data  = hit_data_ff | (BYTE_W'(bit_ff) << hit_cnt_ff);
   assign completes = hit_ff && (hit_cnt_ff == LAST_POS);
   assign rsp_fire  = cmd.update && (completes || (!hit_ff && !free_ff));

   assign stat.scan_done = hit_ff || (!issue_ff && !chk_ff);
   assign stat.needs_rsp = completes || (!hit_ff && !free_ff);
   assign stat.rsp_busy  = rsp_valid_ff && !rsp_ready;

   // capture the incoming transaction
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         who_ff <= req_sender_id;
         bit_ff <= req_bit_value;
      end
   end

   // scan issue stage: one table read per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         chk_ff   <= 1'b0;
      end else if (cmd.load) begin
         issue_ff <= 1'b1;
         chk_ff   <= 1'b0;
      end else if (cmd.scan) begin
         chk_ff <= issue_ff;
         if (issue_ff && idx_ff == LastIdx) begin
            issue_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff <= '0;
      end else if (cmd.scan && issue_ff) begin
         idx_ff    <= idx_ff + 1'b1;
         rd_ff     <= mem[idx_ff];
         rd_idx_ff <= idx_ff;
      end
   end

   // scan check stage: first match, lowest free entry
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (cmd.load) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (cmd.scan) begin
         if (is_match && !hit_ff) begin
            hit_ff <= 1'b1;
         end
         if (is_free && !free_ff) begin
            free_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan && is_match && !hit_ff) begin
         hit_idx_ff  <= rd_idx_ff;
         hit_cnt_ff  <= rd_ff.count;
         hit_data_ff <= rd_ff.data;
      end
      if (cmd.scan && is_free && !free_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
   end

   // entry update: extend, complete or claim
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         if (hit_ff && !completes) begin
            mem[hit_idx_ff] <= '{sender: who_ff, count: hit_cnt_ff + 1'b1, data: new_data};
         end else if (!hit_ff && free_ff) begin
            mem[free_idx_ff] <= '{sender: who_ff, count: count_type'(1),
                                  data: BYTE_W'(bit_ff)};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.update) begin
         if (completes) begin
            valid_ff[hit_idx_ff] <= 1'b0;
         end else if (!hit_ff && free_ff) begin
            valid_ff[free_idx_ff] <= 1'b1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire) begin
         rsp_sender_ff <= who_ff;
         if (completes) begin
            rsp_data_ff   <= new_data;
            rsp_status_ff <= STATUS_COMPLETE;
         end else begin
            rsp_data_ff   <= '0;
            rsp_status_ff <= STATUS_DROPPED;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_sender = rsp_sender_ff;
   assign rsp_data_byte     = rsp_data_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

[sv/multi_sender_bit_assembler.sv]
// ---------------------------------------------------------------------------
// multi_sender_bit_assembler
// Per-sender serial-to-parallel byte assembly over a small table.
// ---------------------------------------------------------------------------
// Each transaction on req_chan carries one bit and a sender id. The block
// scans its table of SENDER_SLOTS open assemblies one entry per cycle
// (a registered memory read followed by a compare), stopping at the first
// match; a miss scans the whole table and claims the lowest free entry.
// Bits fill LSB first; the eighth bit returns the sender and byte with
// status 0 and frees the entry. A bit from a new sender while the table is
// full is dropped and returns the sender, a zero byte and status 1. One
// transaction is handled at a time, paced by the single-port table scan. A
// result waits in an output register while the next transaction is
// accepted; the update stalls only when it has a new result and that
// register is still held by a stalled result channel.
// ---------------------------------------------------------------------------
module multi_sender_bit_assembler import msba_pkg::*; #(
   parameter int SENDER_SLOTS = SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   msba_req_if.sink    req_chan,
   msba_rsp_if.source  rsp_chan
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   msba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // table and result datapath
   msba_dpath #(
      .SENDER_SLOTS (SENDER_SLOTS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_sender_id     (req_chan.sender_id),
      .req_bit_value     (req_chan.bit_value),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_result_sender (rsp_chan.result_sender),
      .rsp_data_byte     (rsp_chan.data_byte),
      .rsp_status        (rsp_chan.status)
   );

endmodule

[dv/msba_assembly_check.sv]
// ---------------------------------------------------------------------------
// msba_assembly_check
// Watches both channels of the bit assembler, predicts each result and
// compares it against what the block returns.
// ---------------------------------------------------------------------------
// Every accepted request updates a private copy of the sender table and may
// queue one predicted result: a completed byte or a dropped-bit notice.
// Every accepted response is compared with the oldest queued prediction.
// The error count and the number of results still owed go to the top.
// ---------------------------------------------------------------------------
module msba_assembly_check import msba_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   msba_req_if  req,
   msba_rsp_if  rsp,
   output int   errors,
   output int   outstanding,
   output int   bytes_seen,
   output int   drops_seen
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      sender_type sender;
      byte_type   data;
      logic       status;
   } byte_result_type;

   // predicted results, oldest first
   byte_result_type pending_bytes[$];

   // shadow of the assembly table
   logic       slot_live  [SLOTS];
   sender_type slot_owner [SLOTS];
   count_type  slot_pos   [SLOTS];
   byte_type   slot_bits  [SLOTS];

   // apply one received bit to the shadow table
   task automatic assemble_bit(input sender_type who, input logic b);
      int              hit;
      byte_result_type res;
      hit = -1;
      // lowest matching open entry wins
      for (int k = 0; k < SLOTS; k++) begin
         if (hit < 0 && slot_live[k] && slot_owner[k] == who) hit = k;
      end
      // miss: claim lowest free entry
      for (int k = 0; k < SLOTS; k++) begin
         if (hit < 0 && !slot_live[k]) begin
            hit           = k;
            slot_live[k]  = 1'b1;
            slot_owner[k] = who;
            slot_pos[k]   = '0;
            slot_bits[k]  = '0;
         end
      end
      // table full: bit dropped, state untouched
      if (hit < 0) begin
         res = '{sender: who, data: '0, status: STATUS_DROPPED};
         pending_bytes.push_back(res);
         return;
      end
      slot_bits[hit] = slot_bits[hit] | (byte_type'(b) << slot_pos[hit]);
      if (slot_pos[hit] == LAST_POS) begin
         res = '{sender: who, data: slot_bits[hit], status: STATUS_COMPLETE};
         pending_bytes.push_back(res);
         slot_live[hit] = 1'b0;
      end else begin
         slot_pos[hit] = slot_pos[hit] + 1'b1;
      end
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin
      byte_result_type oldest;
      byte_result_type actual;
      if (reset) begin
         for (int k = 0; k < SLOTS; k++) slot_live[k] = 1'b0;
         pending_bytes.delete();
         errors     = 0;
         bytes_seen = 0;
         drops_seen = 0;
      end else begin
         // response side first: a result never belongs to a request of this edge
         if (rsp.valid && rsp.ready) begin
            actual = '{sender: rsp.result_sender, data: rsp.data_byte,
                       status: rsp.status};
            if (actual.status == STATUS_DROPPED) drops_seen++;
            else bytes_seen++;
            if (pending_bytes.size() == 0) begin
               errors++;
               $display("%0t: unexpected transaction: sender %h byte %h status %b",
                        $time, actual.sender, actual.data, actual.status);
            end else begin
               oldest = pending_bytes.pop_front();
               if (oldest.sender !== actual.sender || oldest.data !== actual.data ||
                   oldest.status !== actual.status) begin
                  errors++;
                  $display("%0t: mismatch: expected %h/%h/%b actual %h/%h/%b",
                           $time, oldest.sender, oldest.data, oldest.status,
                           actual.sender, actual.data, actual.status);
               end
            end
         end
         if (req.valid && req.ready) assemble_bit(req.sender_id, req.bit_value);
      end
      outstanding = pending_bytes.size();
   end

endmodule

[dv/multi_sender_bit_assembler_tb.sv]
// ---------------------------------------------------------------------------
// multi_sender_bit_assembler_tb
// Stimulus and verdict for the multi-sender bit assembler.
// ---------------------------------------------------------------------------
// A directed opening covers all-ones and all-zeros bytes at the extreme
// sender ids, fills the table and drops a bit from a new sender. The
// random part runs bursts of interleaved senders that each send whole
// bytes, and bursts that fill the table and then push stray senders into
// it. Both channels idle at random; some bursts run without any idling.
// ---------------------------------------------------------------------------
module multi_sender_bit_assembler_tb;
   import msba_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int         SLOTS       = SLOTS_DEFAULT;
   localparam int         ITEM_TARGET = 950;
   localparam sender_type MAX_ID      = '1;

   logic clock = 1'b0;
   logic reset;

   int errors;
   int outstanding;
   int bytes_seen;
   int drops_seen;
   int items_sent;
   bit calm;

   // senders of the current burst and bits each still has to send
   sender_type burst_ids[$];
   int         bits_left[$];

   msba_req_if req_chan();
   msba_rsp_if rsp_chan();

   multi_sender_bit_assembler #(.SENDER_SLOTS(SLOTS)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   msba_assembly_check #(.SLOTS(SLOTS)) i_check (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .errors      (errors),
      .outstanding (outstanding),
      .bytes_seen  (bytes_seen),
      .drops_seen  (drops_seen)
   );

   always #6 clock = ~clock;

   // one request transaction; returns after the accepting edge
   task automatic send_bit(input sender_type id, input logic b);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.sender_id <= id;
      req_chan.bit_value <= b;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   // sender id not yet used in this burst, biased toward the extremes
   function automatic sender_type fresh_id();
      sender_type id;
      bit         taken;
      do begin
         case ($urandom_range(0, 9))
            0:       id = '0;
            1:       id = MAX_ID;
            2, 3:    id = sender_type'($urandom_range(0, 15));
            default: id = sender_type'($urandom);
         endcase
         taken = 1'b0;
         foreach (burst_ids[k]) if (burst_ids[k] == id) taken = 1'b1;
      end while (taken);
      return id;
   endfunction

   // random interleave of the burst until every sender is done
   task automatic drain_burst();
      int total;
      int k;
      total = 0;
      foreach (bits_left[i]) total += bits_left[i];
      while (total > 0) begin
         k = $urandom_range(0, burst_ids.size() - 1);
         if (bits_left[k] > 0) begin
            send_bit(burst_ids[k], logic'($urandom_range(0, 1)));
            bits_left[k]--;
            total--;
         end
      end
      burst_ids.delete();
      bits_left.delete();
   endtask

   // whole bytes from up to SLOTS senders, never filling past the table
   task automatic byte_burst();
      int n;
      n = $urandom_range(1, SLOTS);
      repeat (n) begin
         burst_ids.push_back(fresh_id());
         bits_left.push_back(BYTE_W * $urandom_range(1, 2));
      end
      drain_burst();
   endtask

   // fill the table, push strays at it, then finish the open bytes
   task automatic overflow_burst();
      int         strays;
      sender_type stray;
      repeat (SLOTS) begin
         burst_ids.push_back(fresh_id());
         bits_left.push_back(BYTE_W - 1);
         send_bit(burst_ids[burst_ids.size() - 1], logic'($urandom_range(0, 1)));
      end
      strays = $urandom_range(1, 3);
      repeat (strays) begin
         stray = fresh_id();
         send_bit(stray, logic'($urandom_range(0, 1)));
      end
      drain_burst();
   endtask

   // result side: random stall before each transaction
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         @(negedge clock);
      end
   end

   // stimulus and verdict
   initial begin
      sender_type opener [SLOTS];
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.sender_id <= '0;
      req_chan.bit_value <= 1'b0;
      items_sent = 0;
      calm       = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // all-ones byte at the top id, all-zeros byte at id zero
      for (int i = 0; i < BYTE_W; i++) begin
         send_bit(MAX_ID, 1'b1);
         send_bit('0, 1'b0);
      end

      // open every entry, then a new sender finds the table full
      opener = '{22'h000000, 22'h3FFFFF, 22'h000001, 22'h200000,
                 22'h2AAAAA, 22'h155555, 22'h0F0F0F, 22'h30C30C};
      foreach (opener[k]) begin
         send_bit(opener[k], logic'(k % 2));
         burst_ids.push_back(opener[k]);
         bits_left.push_back(BYTE_W - 1);
      end
      send_bit(22'h3FFFFE, 1'b1);

      // random part starts by closing the open entries
      drain_burst();
      while (items_sent < ITEM_TARGET) begin
         calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) == 0) overflow_burst();
         else byte_burst();
      end
      calm = 1'b0;
      @(negedge clock);
      req_chan.valid <= 1'b0;

      // let the last results drain
      while (outstanding != 0) @(posedge clock);
      repeat (4 * SLOTS) @(posedge clock);

      $display("Sent %0d bits from interleaved senders; %0d bytes assembled, %0d bits dropped",
               items_sent, bytes_seen, drops_seen);
      $display("on a full table, with random idling on both channels.");
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog
   initial begin
      #3ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

[filelist.f]
sv/msba_pkg.sv
sv/msba_req_if.sv
sv/msba_rsp_if.sv
sv/msba_ctrl.sv
sv/msba_dpath.sv
sv/multi_sender_bit_assembler.sv
dv/msba_assembly_check.sv
dv/multi_sender_bit_assembler_tb.sv
